>>> rtl/lphm_pkg.sv
`default_nettype none

package lphm_pkg;

    typedef logic [2:0] outcome_t;

    localparam outcome_t OUTCOME_INSERTED  = 3'd0;
    localparam outcome_t OUTCOME_DUPLICATE = 3'd1;
    localparam outcome_t OUTCOME_FULL      = 3'd2;
    localparam outcome_t OUTCOME_FOUND     = 3'd3;
    localparam outcome_t OUTCOME_NOT_FOUND = 3'd4;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam int IN_KEY_W   = 32;
    localparam int IN_VALUE_W = 32;

endpackage

`default_nettype wire

>>> rtl/linear_probe_hash_map.sv
`default_nettype none
// Flow: an item passes key reduction (ST_HASH, only if TABLE_SLOTS is not a power of two), ST_START,
// one ST_LOOK step per probed slot (1..TABLE_SLOTS) and ST_EMIT before its result beat.
// Throughput: one item at a time; slots are probed one per cycle from a single-port-read table RAM.
// A finished result waits in the output register while the next item is accepted.
// Reset: after rst_n the table is swept empty, one slot a cycle, through every slot;
// in_ready stays low during the sweep.
module linear_probe_hash_map #(
    parameter int TABLE_SLOTS = 1024,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  kind,
    input  wire logic [31:0]           key,
    input  wire logic [31:0]           insert_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lphm_pkg::outcome_t         outcome,
    output logic [31:0]                found_value
);

    localparam int SLOT_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int WORD_W    = 1 + KEY_BITS + VALUE_BITS;
    localparam int KIN       = (KEY_BITS < lphm_pkg::IN_KEY_W) ? KEY_BITS : lphm_pkg::IN_KEY_W;
    localparam int VIN       = (VALUE_BITS < lphm_pkg::IN_VALUE_W) ? VALUE_BITS
                                                                    : lphm_pkg::IN_VALUE_W;
    localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    // floor(key / slots) = (key * RECIP) >> RECIP_SHIFT, exact for every 32-bit key
    localparam int          RECIP_SHIFT = 32 + SLOT_BITS;
    localparam logic [32:0] RECIP       = 33'((64'd1 << RECIP_SHIFT) / 64'(TABLE_SLOTS) + 64'd1);
    localparam logic [31:0] SLOTS_W32   = 32'(TABLE_SLOTS);

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_LOOK  = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    // table RAM: {used, key, value}
    logic [WORD_W-1:0]    mem [TABLE_SLOTS];
    logic [WORD_W-1:0]    rd_data;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    logic [WORD_W-1:0]    wr_data;

    logic [2:0]            state_reg, state_next;
    logic [SLOT_BITS-1:0]  clr_reg, clr_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  kind_reg, kind_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [31:0]           hkey_reg, hkey_next;
    logic [31:0]           quot_reg, quot_next;
    logic                  step_reg, step_next;
    logic [SLOT_BITS-1:0]  pos_reg, pos_next;
    logic [SLOT_BITS-1:0]  cnt_reg, cnt_next;
    lphm_pkg::outcome_t    res_outcome_reg, res_outcome_next;
    logic [31:0]           res_value_reg, res_value_next;
    lphm_pkg::outcome_t    outcome_reg, outcome_next;
    logic [31:0]           found_value_reg, found_value_next;

    logic [31:0]           key_in;
    logic [64:0]           recip_prod;
    logic [31:0]           quot_times_n;
    logic [31:0]           key_rem;
    logic [SLOT_BITS-1:0]  next_pos;
    logic                  slot_used;
    logic [KEY_BITS-1:0]   slot_key;
    logic [VALUE_BITS-1:0] slot_value;
    logic                  accept;
    logic                  out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign slot_used  = rd_data[WORD_W-1];
    assign slot_key   = rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
    assign slot_value = rd_data[VALUE_BITS-1:0];

    assign key_in   = 32'(key[KIN-1:0]);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign next_pos     = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign recip_prod   = {33'd0, hkey_reg} * {32'd0, RECIP};
    assign quot_times_n = quot_reg * SLOTS_W32;
    assign key_rem      = hkey_reg - quot_times_n;

    // in LOOK the next slot is read speculatively so one slot is checked per cycle
    assign rd_addr = (state_reg == ST_LOOK) ? next_pos : pos_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        val_next         = val_reg;
        hkey_next        = hkey_reg;
        quot_next        = quot_reg;
        step_next        = step_reg;
        pos_next         = pos_reg;
        cnt_next         = cnt_reg;
        res_outcome_next = res_outcome_reg;
        res_value_next   = res_value_reg;
        outcome_next     = outcome_reg;
        found_value_next = found_value_reg;
        in_ready         = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = {1'b1, key_reg, val_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    kind_next = kind;
                    key_next  = KEY_BITS'(key[KIN-1:0]);
                    val_next  = VALUE_BITS'(insert_value[VIN-1:0]);
                    cnt_next  = '0;
                    hkey_next = key_in;
                    step_next = 1'b0;
                    if (SLOTS_POW2)
                    begin
                        pos_next   = key_in[SLOT_BITS-1:0];
                        state_next = ST_START;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                // quotient first, then key minus quotient times slots
                if (!step_reg)
                begin
                    quot_next = 32'(recip_prod >> RECIP_SHIFT);
                    step_next = 1'b1;
                end
                else
                begin
                    pos_next   = key_rem[SLOT_BITS-1:0];
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                res_value_next = '0;
                if (!slot_used)
                begin
                    if (kind_reg == lphm_pkg::KIND_INSERT)
                    begin
                        wr_en            = 1'b1;
                        res_outcome_next = lphm_pkg::OUTCOME_INSERTED;
                    end
                    else
                    begin
                        res_outcome_next = lphm_pkg::OUTCOME_NOT_FOUND;
                    end
                    state_next = ST_EMIT;
                end
                else if (slot_key == key_reg)
                begin
                    if (kind_reg == lphm_pkg::KIND_INSERT)
                    begin
                        res_outcome_next = lphm_pkg::OUTCOME_DUPLICATE;
                    end
                    else
                    begin
                        res_outcome_next = lphm_pkg::OUTCOME_FOUND;
                        res_value_next   = 32'(slot_value[VIN-1:0]);
                    end
                    state_next = ST_EMIT;
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    res_outcome_next = (kind_reg == lphm_pkg::KIND_INSERT)
                                       ? lphm_pkg::OUTCOME_FULL
                                       : lphm_pkg::OUTCOME_NOT_FOUND;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pos_next = next_pos;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    outcome_next     = res_outcome_reg;
                    found_value_next = res_value_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        key_reg         <= key_next;
        val_reg         <= val_next;
        hkey_reg        <= hkey_next;
        quot_reg        <= quot_next;
        step_reg        <= step_next;
        pos_reg         <= pos_next;
        cnt_reg         <= cnt_next;
        res_outcome_reg <= res_outcome_next;
        res_value_reg   <= res_value_next;
        outcome_reg     <= outcome_next;
        found_value_reg <= found_value_next;
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign found_value = found_value_reg;

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SLOTS = 1024;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        lphm_pkg::outcome_t outcome;
        logic [31:0]        value;
    } table_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = lphm_pkg::KIND_INSERT;
    logic [31:0]        key = '0;
    logic [31:0]        insert_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    lphm_pkg::outcome_t outcome;
    logic [31:0]        found_value;

    // shadow copy of the table
    bit          tbl_used [SLOTS];
    logic [31:0] tbl_key [SLOTS];
    logic [31:0] tbl_val [SLOTS];
    logic [31:0] held_keys [$];
    bit          held_set [logic [31:0]];

    table_reply_t pending_replies [$];
    table_reply_t want;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int ops_sent = 0;
    int replies_checked = 0;
    int outcome_hits [5];
    int cycles = 0;

    linear_probe_hash_map #(
        .TABLE_SLOTS(SLOTS),
        .KEY_BITS   (32),
        .VALUE_BITS (32)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .key         (key),
        .insert_value(insert_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .outcome     (outcome),
        .found_value (found_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_replies.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic table_reply_t probe_table(input logic op, input logic [31:0] k,
                                                 input logic [31:0] v);
        table_reply_t r;
        int unsigned pos;
        int n;
        bit done;
        r.outcome = (op == lphm_pkg::KIND_INSERT) ? lphm_pkg::OUTCOME_FULL
                                                  : lphm_pkg::OUTCOME_NOT_FOUND;
        r.value = '0;
        pos = k % SLOTS;
        n = 0;
        done = 0;
        while (!done && n < SLOTS)
        begin
            if (!tbl_used[pos])
            begin
                if (op == lphm_pkg::KIND_INSERT)
                begin
                    tbl_used[pos] = 1'b1;
                    tbl_key[pos] = k;
                    tbl_val[pos] = v;
                    held_keys.push_back(k);
                    held_set[k] = 1'b1;
                    r.outcome = lphm_pkg::OUTCOME_INSERTED;
                end
                else
                begin
                    r.outcome = lphm_pkg::OUTCOME_NOT_FOUND;
                end
                done = 1;
            end
            else if (tbl_key[pos] == k)
            begin
                if (op == lphm_pkg::KIND_INSERT)
                begin
                    r.outcome = lphm_pkg::OUTCOME_DUPLICATE;
                end
                else
                begin
                    r.outcome = lphm_pkg::OUTCOME_FOUND;
                    r.value = tbl_val[pos];
                end
                done = 1;
            end
            else
            begin
                pos = (pos + 1) % SLOTS;
                n++;
            end
        end
        return r;
    endfunction

    // Called and returns just after a falling edge; valid stays high on return.
    task automatic issue_op(input logic op, input logic [31:0] k, input logic [31:0] v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind <= op;
        key <= k;
        insert_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        pending_replies.push_back(probe_table(op, k, v));
        ops_sent++;
        @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            replies_checked++;
            if (outcome < 5)
                outcome_hits[outcome]++;
            if (pending_replies.size() == 0)
            begin
                flag_mismatch("unexpected result, outcome", '0, {29'd0, outcome});
            end
            else
            begin
                want = pending_replies.pop_front();
                if (outcome !== want.outcome)
                    flag_mismatch("outcome", {29'd0, want.outcome}, {29'd0, outcome});
                if (found_value !== want.value)
                    flag_mismatch("found_value", want.value, found_value);
            end
        end
    end

    task automatic test_directed();
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'h1234_5678);   // empty table
        issue_op(lphm_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);   // last slot
        issue_op(lphm_pkg::KIND_INSERT, 32'h0000_03FF, 32'h0000_0001);   // wraps past slot 0
        issue_op(lphm_pkg::KIND_INSERT, 32'h0000_0000, 32'h0000_007B);   // duplicate
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h0000_03FF, 32'h0000_00FF);   // found after wrap
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h0000_07FF, 32'h0000_0000);   // miss after wrap
        issue_op(lphm_pkg::KIND_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        issue_op(lphm_pkg::KIND_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h5555_5555, 32'h0000_0000);
        // home 0, lands behind cluster
        issue_op(lphm_pkg::KIND_INSERT, 32'h0000_0400, 32'h8000_0000);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h0000_0400, 32'h0000_0000);
        // duplicate keeps old value
        issue_op(lphm_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_INSERT, 32'h8000_0000, 32'h0000_0001);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000);
        issue_op(lphm_pkg::KIND_LOOKUP, 32'h8000_0400, 32'h0000_0000);
    endtask

    task automatic test_random_mix(input int count);
        logic [31:0] k;
        logic [31:0] v;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35 && held_keys.size() != 0)
                k = held_keys[$urandom_range(held_keys.size() - 1)];
            else if (pick < 60 && held_keys.size() != 0)
                // same home slot as a stored key, most likely absent
                k = (held_keys[$urandom_range(held_keys.size() - 1)] & 32'h0000_03FF)
                    | ($urandom() & 32'hFFFF_FC00);
            else if (pick < 65)
                case ($urandom_range(3))
                    0: k = 32'h0000_0000;
                    1: k = 32'hFFFF_FFFF;
                    2: k = 32'h0000_03FF;
                    default: k = 32'hFFFF_FC00;
                endcase
            else
                k = $urandom();
            pick = $urandom_range(99);
            if (pick < 3)
                v = 32'h0000_0000;
            else if (pick < 6)
                v = 32'hFFFF_FFFF;
            else
                v = $urandom();
            issue_op($urandom_range(1) ? lphm_pkg::KIND_LOOKUP : lphm_pkg::KIND_INSERT, k, v);
        end
    endtask

    task automatic test_fill_and_overflow();
        logic [31:0] k;
        // each empty slot gets a key whose home is that slot, so one probe each
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!tbl_used[s])
                issue_op(lphm_pkg::KIND_INSERT, ($urandom() & 32'hFFFF_FC00) | s, $urandom());
        end
        for (int i = 0; i < 3; i++)
        begin
            do
                k = $urandom();
            while (held_set.exists(k));
            issue_op(lphm_pkg::KIND_INSERT, k, $urandom());     // table full
            issue_op(lphm_pkg::KIND_LOOKUP, k, $urandom());     // miss after a full wrap
            issue_op(lphm_pkg::KIND_LOOKUP, held_keys[$urandom_range(held_keys.size() - 1)], 0);
            issue_op(lphm_pkg::KIND_INSERT, held_keys[$urandom_range(held_keys.size() - 1)],
                     $urandom());
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_gap_pct = 12;
        recv_stall_pct = 83;
        test_directed();
        test_random_mix(250);

        send_gap_pct = 83;
        recv_stall_pct = 12;
        test_random_mix(250);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random_mix(240);
        test_fill_and_overflow();

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d operations, checked %0d results, %0d mismatches",
                 ops_sent, replies_checked, mismatches);
        $display("Outcomes: inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d",
                 outcome_hits[0], outcome_hits[1], outcome_hits[2], outcome_hits[3],
                 outcome_hits[4]);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
